// File: rtl/core/sqfk_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sqfk_pkg
// shared types and codes of the square-free kernel sieve block
// ----------------------------------------------------------------------------
package sqfk_pkg;

    localparam logic ACT_REBUILD = 1'b0;
    localparam logic ACT_QUERY   = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_REBUILT   = 2'd1;
    localparam logic [1:0] STATUS_RANGE     = 2'd2;
    localparam logic [1:0] STATUS_NOT_BUILT = 2'd3;

    localparam logic [15:0] LIMIT_RESET = 16'hFFFF;
    localparam logic [15:0] LIMIT_MIN   = 16'd2;

    // table entry: least prime factor and the cofactor value / factor
    typedef struct packed {
        logic [15:0] spf;
        logic [15:0] cof;
    } lf_entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RCLR,
        S_RRDI,
        S_RCHKI,
        S_RRDP,
        S_RMUL,
        S_RCMP,
        S_RNEXT,
        S_QRD,
        S_QCHK,
        S_QMW,
        S_QFIN,
        S_QFW,
        S_DONE
    } state_t;

endpackage
`default_nettype wire

// File: rtl/core/sqfk_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sqfk channel interfaces
// request, response and configuration channels with valid/ready
// ----------------------------------------------------------------------------
interface sqfk_req_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [15:0] query_value;
    modport source (output valid, output action, output query_value, input ready);
    modport sink   (input valid, input action, input query_value, output ready);
endinterface

interface sqfk_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] kernel;
    logic [1:0]  status;
    modport source (output valid, output kernel, output status, input ready);
    modport sink   (input valid, input kernel, input status, output ready);
endinterface

interface sqfk_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/square_free_kernel_by_prime_sieve.sv
`default_nettype none
// ----------------------------------------------------------------------------
// square_free_kernel_by_prime_sieve
// linear sieve of least prime factors and square-free kernel queries
// ----------------------------------------------------------------------------
// One transaction at a time. A rebuild clears table entries 0..L, then walks
// i = 2..L, trying products i*p against the prime list; it stops early, with
// the built limit set below L, when the prime list is full. The single table
// port and the shared multiplier set its pace. A query walks the prime factors
// of its value counted with multiplicity and multiplies in each distinct prime
// with odd exponent; error answers skip the table and go straight to the output.
// The result sits in an output register, so the next transaction is taken
// while it waits.
// ----------------------------------------------------------------------------
module square_free_kernel_by_prime_sieve
    import sqfk_pkg::*;
#(
    parameter int TABLE_ENTRIES = 65536,
    parameter int PRIME_SLOTS   = 8192
) (
    input  wire logic clk,
    input  wire logic rst_n,
    sqfk_cfg_if.sink  cfg,
    sqfk_req_if.sink  req,
    sqfk_rsp_if.source rsp
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int PW = $clog2(PRIME_SLOTS);
    localparam int CW = PW + 1;
    localparam logic [15:0] MAX_LIM =
        (TABLE_ENTRIES - 1 > 65535) ? 16'hFFFF : 16'(TABLE_ENTRIES - 1);
    localparam logic [CW-1:0] SLOTS_FULL = CW'(PRIME_SLOTS);

    // memories
    lf_entry_t   lf_mem [TABLE_ENTRIES];
    logic [15:0] pl_mem [PRIME_SLOTS];

    lf_entry_t   lf_rd_reg;
    logic [15:0] pl_rd_reg;

    logic [AW-1:0] lf_addr;
    logic          lf_we;
    lf_entry_t     lf_wd;
    logic          pl_we;

    // registers
    state_t        state_reg, state_next;
    logic [15:0]   sieve_limit_reg, sieve_limit_next;
    logic [15:0]   lim_reg, lim_next;
    logic [15:0]   built_reg, built_next;
    logic          ready_reg, ready_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] k_reg, k_next;
    logic [15:0]   i_reg, i_next;
    logic [15:0]   spf_reg, spf_next;
    logic [15:0]   p_reg, p_next;
    logic [15:0]   x_reg, x_next;
    logic [15:0]   cur_reg, cur_next;
    logic          odd_reg, odd_next;
    logic [15:0]   res_reg, res_next;
    logic [1:0]    stat_reg, stat_next;
    logic          ov_reg, ov_next;
    logic [15:0]   okern_reg, okern_next;
    logic [1:0]    ostat_reg, ostat_next;

    logic [15:0] mul_a, mul_b;
    logic [31:0] prod;
    logic [15:0] lim_clamp;

    sqfk_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    always_ff @(posedge clk)
    begin
        if (lf_we)
        begin
            lf_mem[lf_addr] <= lf_wd;
        end
        lf_rd_reg <= lf_mem[lf_addr];
        if (pl_we)
        begin
            pl_mem[cnt_reg[PW-1:0]] <= i_reg;
        end
        pl_rd_reg <= pl_mem[k_reg[PW-1:0]];
    end

    assign lim_clamp = (sieve_limit_reg < LIMIT_MIN) ? LIMIT_MIN :
                       (sieve_limit_reg > MAX_LIM) ? MAX_LIM : sieve_limit_reg;

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = ov_reg;
    assign rsp.kernel = okern_reg;
    assign rsp.status = ostat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            sieve_limit_reg <= LIMIT_RESET;
            built_reg       <= '0;
            ready_reg       <= 1'b0;
            cnt_reg         <= '0;
            ov_reg          <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            sieve_limit_reg <= sieve_limit_next;
            built_reg       <= built_next;
            ready_reg       <= ready_next;
            cnt_reg         <= cnt_next;
            ov_reg          <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lim_reg   <= lim_next;
        k_reg     <= k_next;
        i_reg     <= i_next;
        spf_reg   <= spf_next;
        p_reg     <= p_next;
        x_reg     <= x_next;
        cur_reg   <= cur_next;
        odd_reg   <= odd_next;
        res_reg   <= res_next;
        stat_reg  <= stat_next;
        okern_reg <= okern_next;
        ostat_reg <= ostat_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        sieve_limit_next = sieve_limit_reg;
        lim_next         = lim_reg;
        built_next       = built_reg;
        ready_next       = ready_reg;
        cnt_next         = cnt_reg;
        k_next           = k_reg;
        i_next           = i_reg;
        spf_next         = spf_reg;
        p_next           = p_reg;
        x_next           = x_reg;
        cur_next         = cur_reg;
        odd_next         = odd_reg;
        res_next         = res_reg;
        stat_next        = stat_reg;
        ov_next          = ov_reg && !rsp.ready;
        okern_next       = okern_reg;
        ostat_next       = ostat_reg;
        lf_addr          = AW'(x_reg);
        lf_we            = 1'b0;
        lf_wd            = '0;
        pl_we            = 1'b0;
        mul_a            = '0;
        mul_b            = '0;

        if (cfg.valid)
        begin
            sieve_limit_next = cfg.data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.action == ACT_REBUILD)
                    begin
                        lim_next   = lim_clamp;
                        built_next = lim_clamp;
                        cnt_next   = '0;
                        i_next     = '0;
                        state_next = S_RCLR;
                    end
                    else if (!ready_reg)
                    begin
                        res_next   = '0;
                        stat_next  = STATUS_NOT_BUILT;
                        state_next = S_DONE;
                    end
                    else if (req.query_value == 16'd0 || req.query_value > built_reg)
                    begin
                        res_next   = '0;
                        stat_next  = STATUS_RANGE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        x_next     = req.query_value;
                        cur_next   = '0;
                        odd_next   = 1'b0;
                        res_next   = 16'd1;
                        state_next = S_QRD;
                    end
                end
            end
            S_RCLR:
            begin
                lf_addr = AW'(i_reg);
                lf_we   = 1'b1;
                if (i_reg == 16'd1)
                begin
                    lf_wd = '{spf: 16'd1, cof: 16'd1};
                end
                if (i_reg == lim_reg)
                begin
                    i_next     = 16'd2;
                    state_next = S_RRDI;
                end
                else
                begin
                    i_next = i_reg + 16'd1;
                end
            end
            S_RRDI:
            begin
                lf_addr    = AW'(i_reg);
                state_next = S_RCHKI;
            end
            S_RCHKI:
            begin
                k_next = '0;
                if (lf_rd_reg.spf == 16'd0)
                begin
                    if (cnt_reg == SLOTS_FULL)
                    begin
                        built_next = i_reg - 16'd1;
                        ready_next = 1'b1;
                        res_next   = '0;
                        stat_next  = STATUS_REBUILT;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        pl_we      = 1'b1;
                        lf_addr    = AW'(i_reg);
                        lf_we      = 1'b1;
                        lf_wd      = '{spf: i_reg, cof: 16'd1};
                        cnt_next   = cnt_reg + CW'(1);
                        spf_next   = i_reg;
                        state_next = S_RRDP;
                    end
                end
                else
                begin
                    spf_next   = lf_rd_reg.spf;
                    state_next = S_RRDP;
                end
            end
            S_RRDP:
            begin
                state_next = (k_reg >= cnt_reg) ? S_RNEXT : S_RMUL;
            end
            S_RMUL:
            begin
                p_next     = pl_rd_reg;
                mul_a      = i_reg;
                mul_b      = pl_rd_reg;
                state_next = S_RCMP;
            end
            S_RCMP:
            begin
                if (prod > {16'd0, lim_reg})
                begin
                    state_next = S_RNEXT;
                end
                else
                begin
                    lf_addr = AW'(prod[15:0]);
                    lf_we   = 1'b1;
                    lf_wd   = '{spf: p_reg, cof: i_reg};
                    if (p_reg == spf_reg)
                    begin
                        state_next = S_RNEXT;
                    end
                    else
                    begin
                        k_next     = k_reg + CW'(1);
                        state_next = S_RRDP;
                    end
                end
            end
            S_RNEXT:
            begin
                if (i_reg == lim_reg)
                begin
                    ready_next = 1'b1;
                    res_next   = '0;
                    stat_next  = STATUS_REBUILT;
                    state_next = S_DONE;
                end
                else
                begin
                    i_next     = i_reg + 16'd1;
                    state_next = S_RRDI;
                end
            end
            S_QRD:
            begin
                lf_addr    = AW'(x_reg);
                state_next = (x_reg <= 16'd1) ? S_QFIN : S_QCHK;
            end
            S_QCHK:
            begin
                if (lf_rd_reg.spf < 16'd2)
                begin
                    state_next = S_QFIN;
                end
                else
                begin
                    x_next     = lf_rd_reg.cof;
                    state_next = S_QRD;
                    if (lf_rd_reg.spf != cur_reg)
                    begin
                        cur_next = lf_rd_reg.spf;
                        odd_next = 1'b1;
                        if (odd_reg)
                        begin
                            mul_a      = res_reg;
                            mul_b      = cur_reg;
                            state_next = S_QMW;
                        end
                    end
                    else
                    begin
                        odd_next = !odd_reg;
                    end
                end
            end
            S_QMW:
            begin
                res_next   = prod[15:0];
                state_next = S_QRD;
            end
            S_QFIN:
            begin
                stat_next = STATUS_OK;
                if (odd_reg)
                begin
                    mul_a      = res_reg;
                    mul_b      = cur_reg;
                    state_next = S_QFW;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_QFW:
            begin
                res_next   = prod[15:0];
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!ov_reg || rsp.ready)
                begin
                    ov_next    = 1'b1;
                    okern_next = res_reg;
                    ostat_next = stat_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("block ready again right after a transaction");

    a_ok_kernel_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == STATUS_OK |-> rsp.kernel != 16'd0)
        else $error("ok result with zero kernel");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= SLOTS_FULL)
        else $error("prime count beyond list size");

    a_ready_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(ready_reg))
        else $error("table ready flag dropped");
`endif

endmodule
`default_nettype wire

// File: rtl/core/sqfk_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sqfk_mul
// shared registered 16x16 multiplier
// ----------------------------------------------------------------------------
module sqfk_mul (
    input  wire logic        clk,
    input  wire logic [15:0] a,
    input  wire logic [15:0] b,
    output logic [31:0]      prod
);

    logic [31:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= 32'(a) * 32'(b);
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

// File: dv/testbench.sv
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Checks the square-free kernel sieve block against its own model of the
// linear sieve and of kernel reduction. A table of directed transactions
// covers queries before any rebuild, the full and the smallest limits, zero,
// one and values past the built limit. Random phases then follow with idle
// and stall patterns on both channels, a long receiver hold-off and a sender
// pause until every response has been seen.
// ----------------------------------------------------------------------------
module testbench;
    import sqfk_pkg::*;

    localparam int TABLE_SIZE  = 65536;
    localparam int PRIME_LIMIT = 8192;

    typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic        action;
        logic [15:0] value;
        bit          typed;
        logic [15:0] kernel;
        logic [1:0]  status;
    } dir_row_t;

    typedef struct {
        logic [15:0] kernel;
        logic [1:0]  status;
    } kernel_rsp_t;

    logic clk;
    logic rst_n;

    sqfk_cfg_if cfg_ch ();
    sqfk_req_if req_ch ();
    sqfk_rsp_if rsp_ch ();

    square_free_kernel_by_prime_sieve u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // model state
    bit [15:0]   factor_tab [TABLE_SIZE];
    int unsigned prime_found [$];
    int unsigned built_lim;
    bit          tab_ready;
    logic [15:0] limit_reg;

    kernel_rsp_t pending_rsp [$];
    int          error_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #40000000;
        $display("square_free_kernel_by_prime_sieve test failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR %0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic void sieve_rebuild();
        int unsigned lim;
        int unsigned i;
        int unsigned p;
        int unsigned m;
        lim = 32'(limit_reg);
        if (lim < 2) lim = 2;
        if (lim > TABLE_SIZE - 1) lim = TABLE_SIZE - 1;
        foreach (factor_tab[j]) factor_tab[j] = '0;
        prime_found.delete();
        factor_tab[1] = 16'd1;
        built_lim = lim;
        for (i = 2; i <= lim; i++)
        begin
            if (factor_tab[i] == 0)
            begin
                if (prime_found.size() >= PRIME_LIMIT)
                begin
                    built_lim = i - 1;
                    break;
                end
                prime_found.insert(prime_found.size(), i);
                factor_tab[i] = i[15:0];
            end
            foreach (prime_found[k])
            begin
                p = prime_found[k];
                m = i * p;
                if (m > lim) break;
                factor_tab[m] = p[15:0];
                if (i % p == 0) break;
            end
        end
        tab_ready = 1'b1;
    endfunction

    function automatic logic [15:0] kernel_for(input int unsigned x);
        int unsigned prod;
        int unsigned cur;
        int unsigned p;
        bit          odd;
        prod = 1;
        cur  = 0;
        odd  = 1'b0;
        for (int g = 0; g < 32 && x > 1; g++)
        begin
            p = 32'(factor_tab[x]);
            if (p < 2) break;
            if (p != cur)
            begin
                if (odd) prod *= cur;
                cur = p;
                odd = 1'b0;
            end
            odd ^= 1'b1;
            x /= p;
        end
        if (odd) prod *= cur;
        return prod[15:0];
    endfunction

    function automatic kernel_rsp_t predict_kernel(input logic act, input logic [15:0] v);
        kernel_rsp_t r;
        r.kernel = '0;
        if (act == ACT_REBUILD)
        begin
            sieve_rebuild();
            r.status = STATUS_REBUILT;
        end
        else if (!tab_ready)
            r.status = STATUS_NOT_BUILT;
        else if (v == 0 || v > built_lim)
            r.status = STATUS_RANGE;
        else
        begin
            r.kernel = kernel_for(32'(v));
            r.status = STATUS_OK;
        end
        return r;
    endfunction

    // returns the model's expectation for the accepted transaction
    task automatic send_item(input logic act, input logic [15:0] v, output kernel_rsp_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.action      <= act;
        req_ch.query_value <= v;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        r = predict_kernel(act, v);
    endtask

    task automatic send_checked(input logic act, input logic [15:0] v);
        kernel_rsp_t r;
        send_item(act, v, r);
        pending_rsp.insert(pending_rsp.size(), r);
    endtask

    task automatic write_limit(input logic [15:0] v);
        req_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending_rsp.size() == 0);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        limit_reg = v;
        cfg_ch.valid <= 1'b0;
    endtask

    // response side
    initial
    begin
        kernel_rsp_t e;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_rsp.size() == 0)
                    report_mismatch("response with no transaction outstanding");
                else
                begin
                    e = pending_rsp.pop_front();
                    if (rsp_ch.kernel !== e.kernel)
                        report_mismatch($sformatf("kernel %0d, want %0d",
                                                  rsp_ch.kernel, e.kernel));
                    if (rsp_ch.status !== e.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  rsp_ch.status, e.status));
                end
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    dir_row_t dir_rows [] = '{
        '{ROW_ITEM, ACT_QUERY,   16'd5,     1'b1, 16'd0,     STATUS_NOT_BUILT},
        '{ROW_ITEM, ACT_REBUILD, 16'hFFFF,  1'b1, 16'd0,     STATUS_REBUILT},
        '{ROW_ITEM, ACT_QUERY,   16'd65535, 1'b1, 16'd65535, STATUS_OK},
        '{ROW_ITEM, ACT_QUERY,   16'd0,     1'b1, 16'd0,     STATUS_RANGE},
        '{ROW_ITEM, ACT_QUERY,   16'd1,     1'b1, 16'd1,     STATUS_OK},
        '{ROW_ITEM, ACT_QUERY,   16'd65534, 1'b0, 16'd0,     STATUS_OK},
        '{ROW_ITEM, ACT_QUERY,   16'd65521, 1'b0, 16'd0,     STATUS_OK},
        '{ROW_ITEM, ACT_QUERY,   16'd32768, 1'b0, 16'd0,     STATUS_OK},
        '{ROW_CFG,  ACT_REBUILD, 16'd0,     1'b0, 16'd0,     STATUS_OK},
        '{ROW_ITEM, ACT_REBUILD, 16'h0000,  1'b1, 16'd0,     STATUS_REBUILT},
        '{ROW_ITEM, ACT_QUERY,   16'd2,     1'b1, 16'd2,     STATUS_OK},
        '{ROW_ITEM, ACT_QUERY,   16'd3,     1'b1, 16'd0,     STATUS_RANGE},
        '{ROW_ITEM, ACT_QUERY,   16'd1,     1'b1, 16'd1,     STATUS_OK},
        '{ROW_CFG,  ACT_REBUILD, 16'd1,     1'b0, 16'd0,     STATUS_OK},
        '{ROW_ITEM, ACT_REBUILD, 16'h5A5A,  1'b1, 16'd0,     STATUS_REBUILT},
        '{ROW_ITEM, ACT_QUERY,   16'd2,     1'b1, 16'd2,     STATUS_OK},
        '{ROW_CFG,  ACT_REBUILD, 16'd200,   1'b0, 16'd0,     STATUS_OK},
        '{ROW_ITEM, ACT_REBUILD, 16'hA5A5,  1'b1, 16'd0,     STATUS_REBUILT},
        '{ROW_ITEM, ACT_QUERY,   16'd199,   1'b0, 16'd0,     STATUS_OK},
        '{ROW_ITEM, ACT_QUERY,   16'd200,   1'b0, 16'd0,     STATUS_OK},
        '{ROW_ITEM, ACT_QUERY,   16'd201,   1'b1, 16'd0,     STATUS_RANGE},
        '{ROW_ITEM, ACT_QUERY,   16'd144,   1'b1, 16'd1,     STATUS_OK},
        '{ROW_ITEM, ACT_QUERY,   16'd180,   1'b0, 16'd0,     STATUS_OK}
    };

    // stimulus
    initial
    begin
        kernel_rsp_t r;
        logic        act;
        logic [15:0] v;
        logic [15:0] lim;
        error_count   = 0;
        hold_cycles   = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        tab_ready     = 1'b0;
        built_lim     = 0;
        limit_reg     = LIMIT_RESET;
        foreach (factor_tab[j]) factor_tab[j] = '0;
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.action      = ACT_QUERY;
        req_ch.query_value = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.data        = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[n])
        begin
            if (dir_rows[n].kind == ROW_CFG)
                write_limit(dir_rows[n].value);
            else
            begin
                send_item(dir_rows[n].action, dir_rows[n].value, r);
                if (dir_rows[n].typed)
                begin
                    r.kernel = dir_rows[n].kernel;
                    r.status = dir_rows[n].status;
                end
                pending_rsp.insert(pending_rsp.size(), r);
            end
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 64 : 0;
            recv_idle_pct = (ph == 0) ? 64 : (ph == 1) ? 19 : 0;
            for (int n = 0; n < 183; n++)
            begin
                if (n % 46 == 0)
                begin
                    lim = (n == 46 && ph == 2) ? LIMIT_MIN : 16'($urandom_range(2, 3000));
                    write_limit(lim);
                    send_checked(ACT_REBUILD, 16'($urandom));
                end
                if (ph == 0 && n == 60)
                    hold_cycles = 400;
                if (ph == 1 && n == 90)
                begin
                    req_ch.valid <= 1'b0;
                    @(posedge clk);
                    wait (pending_rsp.size() == 0);
                end
                act = ($urandom_range(99) < 3) ? ACT_REBUILD : ACT_QUERY;
                if ($urandom_range(99) < 15)
                    v = 16'($urandom);
                else
                    v = 16'($urandom_range(0, built_lim + 5));
                send_checked(act, v);
            end
        end

        req_ch.valid <= 1'b0;
        wait (pending_rsp.size() == 0);
        repeat (100) @(posedge clk);
        if (error_count == 0)
            $display("square_free_kernel_by_prime_sieve test passed");
        else
            $display("square_free_kernel_by_prime_sieve test failed");
        $finish;
    end

endmodule
`default_nettype wire
